### sv/tod_pkg.sv
// Shared types, codes and constants of the time-of-day clock with LCD columns.
// Holds the item kind codes, glyph codes, the 8x8 font table and digit helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

  localparam int unsigned TOD_SPLIT_COLUMN = 61;
  localparam logic [15:0] TPS_RESET        = 16'd100;
  localparam logic [7:0]  LINE_COLUMNS     = 8'd120;
  localparam int unsigned FONT_GLYPHS      = 39;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_HOUR_UP = 3'd2,
    KIND_MIN_UP  = 3'd3,
    KIND_CONFIRM = 3'd4,
    KIND_RENDER  = 3'd5
  } kind_e;

  localparam logic [5:0] GLYPH_T     = 6'h1d;
  localparam logic [5:0] GLYPH_I     = 6'h12;
  localparam logic [5:0] GLYPH_M     = 6'h16;
  localparam logic [5:0] GLYPH_E     = 6'h0e;
  localparam logic [5:0] GLYPH_COLON = 6'h24;
  localparam logic [5:0] GLYPH_BLANK = 6'h26;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  typedef struct packed {
    logic       chip_select;
    logic [5:0] chip_column;
    logic [7:0] pixels;
    logic       column_valid;
  } render_t;

  // One byte per column, bit per pixel row; column 0 of each glyph first.
  localparam logic [7:0] FONT_ROM [FONT_GLYPHS][8] = '{
    '{8'h00, 8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h62, 8'h51, 8'h49, 8'h49, 8'h46, 8'h00, 8'h00},
    '{8'h00, 8'h21, 8'h41, 8'h49, 8'h4D, 8'h33, 8'h00, 8'h00},
    '{8'h00, 8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h00},
    '{8'h00, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00, 8'h00},
    '{8'h00, 8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31, 8'h00, 8'h00},
    '{8'h00, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00, 8'h00},
    '{8'h00, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00},
    '{8'h00, 8'h46, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00, 8'h00},
    '{8'h00, 8'h24, 8'h54, 8'h54, 8'h38, 8'h40, 8'h00, 8'h00},
    '{8'h00, 8'h7F, 8'h28, 8'h44, 8'h44, 8'h38, 8'h00, 8'h00},
    '{8'h00, 8'h38, 8'h44, 8'h44, 8'h44, 8'h08, 8'h00, 8'h00},
    '{8'h00, 8'h38, 8'h44, 8'h44, 8'h28, 8'h7F, 8'h00, 8'h00},
    '{8'h00, 8'h38, 8'h54, 8'h54, 8'h54, 8'h08, 8'h00, 8'h00},
    '{8'h00, 8'h08, 8'h7E, 8'h09, 8'h09, 8'h02, 8'h00, 8'h00},
    '{8'h00, 8'h98, 8'hA4, 8'hA4, 8'hA4, 8'h78, 8'h00, 8'h00},
    '{8'h00, 8'h7F, 8'h08, 8'h04, 8'h04, 8'h78, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h80, 8'h88, 8'h79, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h7F, 8'h10, 8'h28, 8'h44, 8'h40, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h41, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h78, 8'h04, 8'h78, 8'h04, 8'h78, 8'h00, 8'h00},
    '{8'h00, 8'h04, 8'h78, 8'h04, 8'h04, 8'h78, 8'h00, 8'h00},
    '{8'h00, 8'h38, 8'h44, 8'h44, 8'h44, 8'h38, 8'h00, 8'h00},
    '{8'h00, 8'hFC, 8'h24, 8'h24, 8'h24, 8'h18, 8'h00, 8'h00},
    '{8'h00, 8'h18, 8'h24, 8'h24, 8'h24, 8'hFC, 8'h00, 8'h00},
    '{8'h00, 8'h04, 8'h78, 8'h04, 8'h04, 8'h08, 8'h00, 8'h00},
    '{8'h00, 8'h48, 8'h54, 8'h54, 8'h54, 8'h24, 8'h00, 8'h00},
    '{8'h00, 8'h04, 8'h3F, 8'h44, 8'h44, 8'h24, 8'h00, 8'h00},
    '{8'h00, 8'h3C, 8'h40, 8'h40, 8'h3C, 8'h40, 8'h00, 8'h00},
    '{8'h00, 8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C, 8'h00, 8'h00},
    '{8'h00, 8'h3C, 8'h40, 8'h3C, 8'h40, 8'h3C, 8'h00, 8'h00},
    '{8'h00, 8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 8'h00, 8'h00},
    '{8'h00, 8'h9C, 8'hA0, 8'hA0, 8'h90, 8'h7C, 8'h00, 8'h00},
    '{8'h00, 8'h44, 8'h64, 8'h54, 8'h4C, 8'h44, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Tens digit of a value below 64, by a short compare chain.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    tens_x10 = 6'({2'b00, tens_of(v)} * 6'd10);
    return 4'(v - tens_x10);
  endfunction

endpackage

`default_nettype wire

### sv/tod_if.sv
// Valid/ready channel interfaces of the time-of-day clock: input items,
// result items and the configuration write channel. Uses tod_pkg types only by width.
`timescale 1ns / 1ps
`default_nettype none

interface tod_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] column;

  modport source (output valid, output kind, output column, input ready);
  modport sink (input valid, input kind, input column, output ready);
endinterface

interface tod_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic       setting;
  logic       chip_select;
  logic [5:0] chip_column;
  logic [7:0] pixels;
  logic       column_valid;

  modport source (output valid, output hours, output minutes, output seconds,
                  output setting, output chip_select, output chip_column,
                  output pixels, output column_valid, input ready);
  modport sink (input valid, input hours, input minutes, input seconds,
                input setting, input chip_select, input chip_column,
                input pixels, input column_valid, output ready);
endinterface

interface tod_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/time_of_day_clock_with_lcd_columns.sv
// Time-of-day clock with LCD column rendering: top level with the time state.
// Depends on tod_pkg, the channel interfaces in tod_if.sv and tod_render.
//
// The block keeps hours, minutes and seconds and answers every accepted
// request with exactly one result that carries the time after that request.
// Tick requests feed a prescaler that advances the seconds once
// ticks_per_second ticks have been counted (reset value 100; a value of zero
// makes every tick a second). A stop request enters set mode, where ticks are
// ignored and hour-up and minute-up step the time; confirm resumes counting.
// A render request returns one column (0..119) of the line "TIME  hh:mm:ss "
// with its controller select and column address; columns below SPLIT_COLUMN
// go to the left controller, the rest to the right one at column minus
// SPLIT_COLUMN. One request is accepted every clock cycle when the result
// side keeps up. An accepted request first waits in the input register,
// where the time update and the font lookup are done together; the answer
// is then captured in the result register, which holds it until taken.
// The result register lets a new request enter while a result waits to be
// taken. The configuration register is meant to be written only while no
// request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_clock_with_lcd_columns #(
  parameter int unsigned SPLIT_COLUMN = tod_pkg::TOD_SPLIT_COLUMN
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tod_in_if.sink     in_i,
  tod_out_if.source  out_o,
  tod_cfg_if.sink    cfg_i
);

  // Input register stage.
  logic       s1_valid_q;
  logic [2:0] s1_kind_q;
  logic [6:0] s1_column_q;

  // Architectural state.
  logic [15:0] tps_q;
  logic [15:0] sub_q, sub_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic        set_q, set_d;

  // Result register.
  logic              out_valid_q;
  tod_pkg::time_t    out_time_q;
  logic              out_set_q;
  tod_pkg::render_t  out_render_q;

  logic              advance;
  logic [16:0]       sub_inc;
  tod_pkg::time_t    cur_time;
  tod_pkg::render_t  render;

  // The second stage moves whenever it holds a request and the result
  // register is free or being emptied in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_kind_q   <= in_i.kind;
      s1_column_q <= in_i.column;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= tod_pkg::TPS_RESET;
    end else if (cfg_i.valid) begin
      tps_q <= cfg_i.data;
    end
  end

  // The prescaler sum is one bit wider so that the compare against the
  // configured count also covers a count lowered below the prescaler value.
  assign sub_inc = {1'b0, sub_q} + 17'd1;

  // Next time state for the request in the second stage. Every counter wraps
  // at its own limit; minute-up and hour-up never carry into the next field.
  always_comb begin
    sub_d  = sub_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    set_d  = set_q;
    case (s1_kind_q)
      tod_pkg::KIND_TICK: begin
        if (!set_q) begin
          if (sub_inc >= {1'b0, tps_q}) begin
            sub_d = '0;
            if (sec_q == 6'd59) begin
              sec_d = '0;
              if (min_q == 6'd59) begin
                min_d  = '0;
                hour_d = (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;
              end else begin
                min_d = min_q + 6'd1;
              end
            end else begin
              sec_d = sec_q + 6'd1;
            end
          end else begin
            sub_d = sub_inc[15:0];
          end
        end
      end
      tod_pkg::KIND_STOP: begin
        set_d = 1'b1;
      end
      tod_pkg::KIND_HOUR_UP: begin
        if (set_q) begin
          hour_d = (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;
        end
      end
      tod_pkg::KIND_MIN_UP: begin
        if (set_q) begin
          min_d = (min_q == 6'd59) ? 6'd0 : min_q + 6'd1;
        end
      end
      tod_pkg::KIND_CONFIRM: begin
        set_d = 1'b0;
      end
      default: begin
        // Render requests and unused kinds leave the time alone.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      set_q  <= 1'b0;
    end else if (advance) begin
      sub_q  <= sub_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      set_q  <= set_d;
    end
  end

  // A render request does not change the time, so the current state is the
  // time shown on the rendered line.
  assign cur_time = '{hours: hour_q, minutes: min_q, seconds: sec_q};

  tod_render #(
    .SPLIT_COLUMN(SPLIT_COLUMN)
  ) u_render (
    .column_i (s1_column_q),
    .time_i   (cur_time),
    .render_o (render)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_time_q <= '{hours: hour_d, minutes: min_d, seconds: sec_d};
      out_set_q  <= set_d;
      out_render_q <= (s1_kind_q == tod_pkg::KIND_RENDER) ? render : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hours        = out_time_q.hours;
  assign out_o.minutes      = out_time_q.minutes;
  assign out_o.seconds      = out_time_q.seconds;
  assign out_o.setting      = out_set_q;
  assign out_o.chip_select  = out_render_q.chip_select;
  assign out_o.chip_column  = out_render_q.chip_column;
  assign out_o.pixels       = out_render_q.pixels;
  assign out_o.column_valid = out_render_q.column_valid;

endmodule

`default_nettype wire

### sv/tod_render.sv
// Column renderer: picks the glyph of the line "TIME  hh:mm:ss " for a column,
// reads its font byte and maps the column onto the two LCD controllers. Uses tod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tod_render #(
  parameter int unsigned SPLIT_COLUMN = tod_pkg::TOD_SPLIT_COLUMN
) (
  input  wire logic [6:0]       column_i,
  input  wire tod_pkg::time_t   time_i,
  output tod_pkg::render_t      render_o
);

  localparam logic [7:0] SplitWide  = 8'(SPLIT_COLUMN);
  localparam logic [7:0] SplitTwice = 8'(2 * SPLIT_COLUMN);
  localparam logic [6:0] SplitNarrow = 7'(SPLIT_COLUMN);

  logic [7:0] col_wide;
  logic       in_line;
  logic [5:0] glyph;
  logic [5:0] glyph_safe;
  logic [6:0] right_col;

  assign col_wide = {1'b0, column_i};
  assign in_line  = (col_wide < tod_pkg::LINE_COLUMNS) && (col_wide < SplitTwice);
  assign right_col = column_i - SplitNarrow;

  always_comb begin
    case (column_i[6:3])
      4'd0:    glyph = tod_pkg::GLYPH_T;
      4'd1:    glyph = tod_pkg::GLYPH_I;
      4'd2:    glyph = tod_pkg::GLYPH_M;
      4'd3:    glyph = tod_pkg::GLYPH_E;
      4'd6:    glyph = {2'b00, tod_pkg::tens_of({1'b0, time_i.hours})};
      4'd7:    glyph = {2'b00, tod_pkg::ones_of({1'b0, time_i.hours})};
      4'd8:    glyph = tod_pkg::GLYPH_COLON;
      4'd9:    glyph = {2'b00, tod_pkg::tens_of(time_i.minutes)};
      4'd10:   glyph = {2'b00, tod_pkg::ones_of(time_i.minutes)};
      4'd11:   glyph = tod_pkg::GLYPH_COLON;
      4'd12:   glyph = {2'b00, tod_pkg::tens_of(time_i.seconds)};
      4'd13:   glyph = {2'b00, tod_pkg::ones_of(time_i.seconds)};
      default: glyph = tod_pkg::GLYPH_BLANK;
    endcase
  end

  assign glyph_safe = (glyph >= 6'(tod_pkg::FONT_GLYPHS)) ? tod_pkg::GLYPH_BLANK : glyph;

  always_comb begin
    render_o = '0;
    if (in_line) begin
      render_o.column_valid = 1'b1;
      render_o.pixels       = tod_pkg::FONT_ROM[glyph_safe][column_i[2:0]];
      if (col_wide < SplitWide) begin
        render_o.chip_select = 1'b0;
        render_o.chip_column = column_i[5:0];
      end else begin
        render_o.chip_select = 1'b1;
        render_o.chip_column = right_col[5:0];
      end
    end
  end

endmodule

`default_nettype wire
